FILE: rtl/core/blocked_bitmap_bit_engine_defines.svh
// ----------------------------------------------------------------------------
// blocked_bitmap_bit_engine_defines
// Assertion macros shared by the blocked bitmap bit engine.
// ----------------------------------------------------------------------------
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef BLOCKED_BITMAP_BIT_ENGINE_DEFINES_SVH
`define BLOCKED_BITMAP_BIT_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define BBBE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BBBE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bbbe_pkg.sv
// ----------------------------------------------------------------------------
// bbbe_pkg
// Shared constants, codes and types of the blocked bitmap bit engine.
// ----------------------------------------------------------------------------
package bbbe_pkg;

  // Bitmap store geometry.
  localparam int unsigned STORE_BYTES = 4096;
  localparam int unsigned STORE_AW    = $clog2(STORE_BYTES);

  // Command codes.
  localparam logic [1:0] CMD_TEST  = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BUFFER  = 2'd0;
  localparam logic [1:0] REG_BLOCK   = 2'd1;
  localparam logic [1:0] REG_HEADER  = 2'd2;
  localparam logic [1:0] REG_TRAILER = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_DIV, ST_MUL, ST_SETUP,
    ST_CHECK, ST_READ, ST_WRITE, ST_TBIT, ST_DONE
  } state_e;

  typedef struct packed {
    logic [12:0] buffer_bytes;
    logic [12:0] block_bytes;
    logic [7:0]  header_bytes;
    logic [7:0]  trailer_bytes;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load;
    logic fail;
    logic div_init;
    logic div_step;
    logic mul;
    logic setup;
    logic rd;
    logic wr;
    logic tbit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_test;
    logic is_run;
    logic empty;
    logic bad;
    logic div_last;
    logic fits;
    logic byte_last;
    logic rem_zero;
  } sts_t;

endpackage

FILE: rtl/core/bbbe_ctrl.sv
// ----------------------------------------------------------------------------
// bbbe_ctrl
// Sequencer of the engine: clearing pass, division, block walk and result.
// ----------------------------------------------------------------------------
`include "blocked_bitmap_bit_engine_defines.svh"

module bbbe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bbbe_pkg::sts_t sts_i,
  output bbbe_pkg::ctl_t ctl_o,
  output logic          busy_o,
  output logic          done_o
);
  import bbbe_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (start_i) state_d = ST_DECODE;
      ST_DECODE: begin
        if (sts_i.is_run && sts_i.empty) state_d = ST_DONE;
        else if (!(sts_i.is_test || sts_i.is_run) || sts_i.bad) state_d = ST_DONE;
        else state_d = ST_DIV;
      end
      ST_DIV:    if (sts_i.div_last) state_d = ST_MUL;
      ST_MUL:    state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_CHECK;
      ST_CHECK:  state_d = sts_i.fits ? ST_READ : ST_DONE;
      ST_READ:   state_d = sts_i.is_test ? ST_TBIT : ST_WRITE;
      ST_TBIT:   state_d = ST_DONE;
      ST_WRITE: begin
        if (!sts_i.byte_last) state_d = ST_READ;
        else if (sts_i.rem_zero) state_d = ST_DONE;
        else state_d = ST_SETUP;
      end
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    ctl_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      ST_CLEAR:  ctl_o.clr_step = 1'b1;
      ST_IDLE: begin
        busy_o     = 1'b0;
        ctl_o.load = start_i;
      end
      ST_DECODE: begin
        if (sts_i.is_run && sts_i.empty) ctl_o.fail = 1'b0;
        else if (!(sts_i.is_test || sts_i.is_run) || sts_i.bad) ctl_o.fail = 1'b1;
        else ctl_o.div_init = 1'b1;
      end
      ST_DIV:    ctl_o.div_step = 1'b1;
      ST_MUL:    ctl_o.mul = 1'b1;
      ST_SETUP:  ctl_o.setup = 1'b1;
      ST_CHECK:  ctl_o.fail = !sts_i.fits;
      ST_READ:   ctl_o.rd = 1'b1;
      ST_TBIT:   ctl_o.tbit = 1'b1;
      ST_WRITE:  ctl_o.wr = 1'b1;
      ST_DONE:   done_o = 1'b1;
      default:   ctl_o = '0;
    endcase
  end

  `BBBE_ASSERT_NXT(a_done_single, state_q == ST_DONE, state_q == ST_IDLE, "result strobe held")
  `BBBE_ASSERT_NXT(a_accept_decode, state_q == ST_IDLE && start_i, state_q == ST_DECODE, "command lost")
  `BBBE_ASSERT_IMP(a_write_after_read, state_q == ST_WRITE, $past(state_q) == ST_READ, "write without read")

endmodule

FILE: rtl/core/bbbe_datapath.sv
// ----------------------------------------------------------------------------
// bbbe_datapath
// Bitmap store, divider, block bounds check and byte read-modify-write.
// ----------------------------------------------------------------------------
module bbbe_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bbbe_pkg::cfg_t cfg_i,
  input  bbbe_pkg::ctl_t ctl_i,
  input  logic [1:0]     command_i,
  input  logic [19:0]    bit_address_i,
  input  logic [15:0]    bit_count_i,
  output bbbe_pkg::sts_t sts_o,
  output logic           status_o,
  output logic           bit_value_o
);
  import bbbe_pkg::*;

  logic [7:0] mem_q [STORE_BYTES];

  logic [1:0]          cmd_q;
  logic [19:0]         addr_q;
  logic [15:0]         rem_q;
  logic [16:0]         div_q;
  logic [12:0]         div_r_q;
  logic [4:0]          div_cnt_q;
  logic [31:0]         base_q;
  logic [15:0]         pos_q;
  logic [16:0]         end_q;
  logic [STORE_AW-1:0] clr_q;
  logic [STORE_AW-1:0] idx_q;
  logic                oob_q;
  logic [7:0]          rdata_q;
  logic                status_q, bitv_q;

  // Layout derived from configuration.
  logic [8:0]  ht_sum;
  logic        bad;
  logic [12:0] data_bytes;
  logic [15:0] data_bits;
  logic [12:0] limit;
  assign ht_sum     = {1'b0, cfg_i.header_bytes} + {1'b0, cfg_i.trailer_bytes};
  assign bad        = cfg_i.block_bytes <= {4'd0, ht_sum};
  assign data_bytes = cfg_i.block_bytes - {4'd0, ht_sum};
  assign data_bits  = {data_bytes, 3'b000};
  assign limit      = (cfg_i.buffer_bytes > 13'(STORE_BYTES)) ? 13'(STORE_BYTES)
                                                              : cfg_i.buffer_bytes;

  // One restoring division step.
  logic [13:0] div_rr;
  logic        div_ge;
  assign div_rr = {div_r_q, div_q[16]};
  assign div_ge = div_rr >= {1'b0, data_bytes};

  // Run length inside the current block.
  logic        is_test;
  logic [15:0] avail;
  logic [15:0] len;
  assign is_test = cmd_q == CMD_TEST;
  assign avail   = data_bits - pos_q;
  assign len     = is_test ? 16'd0 : ((rem_q < avail) ? rem_q : avail);

  // Bounds check and byte address.
  logic [31:0] fit_sum;
  logic [31:0] byte_idx;
  assign fit_sum  = base_q + 32'(cfg_i.header_bytes) + 32'(end_q[16:3])
                  + 32'(cfg_i.trailer_bytes);
  assign byte_idx = base_q + 32'(cfg_i.header_bytes) + 32'(pos_q[15:3]);

  // Byte walk within a block.
  logic [16:0] end_m1;
  logic        byte_last;
  logic [2:0]  hi_bit;
  logic [7:0]  mask;
  logic [7:0]  wdata;
  assign end_m1    = end_q - 17'd1;
  assign byte_last = {1'b0, pos_q[15:3]} == end_m1[16:3];
  assign hi_bit    = byte_last ? end_m1[2:0] : 3'd7;
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      mask[j] = (3'(j) >= pos_q[2:0]) && (3'(j) <= hi_bit);
    end
  end
  assign wdata = (cmd_q == CMD_SET) ? (rdata_q | mask) : (rdata_q & ~mask);

  // Control-side registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      status_q <= 1'b0;
      bitv_q   <= 1'b0;
    end else begin
      if (ctl_i.clr_step) clr_q <= clr_q + 1'b1;
      if (ctl_i.load) begin
        status_q <= 1'b0;
        bitv_q   <= 1'b0;
      end
      if (ctl_i.fail) status_q <= 1'b1;
      if (ctl_i.tbit) bitv_q <= rdata_q[addr_q[2:0]] & !oob_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= command_i;
      addr_q <= bit_address_i;
      rem_q  <= bit_count_i;
    end
    if (ctl_i.div_init) begin
      div_q     <= addr_q[19:3];
      div_r_q   <= '0;
      div_cnt_q <= '0;
    end
    if (ctl_i.div_step) begin
      div_q     <= {div_q[15:0], div_ge};
      div_r_q   <= div_ge ? 13'(div_rr - {1'b0, data_bytes}) : div_rr[12:0];
      div_cnt_q <= div_cnt_q + 5'd1;
    end
    if (ctl_i.mul) begin
      base_q <= 32'(div_q) * 32'(cfg_i.block_bytes);
      pos_q  <= {div_r_q, addr_q[2:0]};
    end
    if (ctl_i.setup) begin
      end_q <= {1'b0, pos_q} + {1'b0, len};
      rem_q <= rem_q - len;
    end
    if (ctl_i.rd) begin
      idx_q <= byte_idx[STORE_AW-1:0];
      oob_q <= byte_idx >= 32'(STORE_BYTES);
    end
    if (ctl_i.wr) begin
      if (!byte_last) begin
        pos_q <= {pos_q[15:3] + 13'd1, 3'b000};
      end else if (rem_q != 16'd0) begin
        base_q <= base_q + 32'(cfg_i.block_bytes);
        pos_q  <= '0;
      end
    end
  end

  // Bitmap store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_step) mem_q[clr_q] <= 8'h00;
    else if (ctl_i.wr && !oob_q) mem_q[idx_q] <= wdata;
    if (ctl_i.rd) rdata_q <= mem_q[byte_idx[STORE_AW-1:0]];
  end

  // Status to the controller.
  always_comb begin
    sts_o.clr_last  = &clr_q;
    sts_o.is_test   = is_test;
    sts_o.is_run    = (cmd_q == CMD_SET) || (cmd_q == CMD_CLEAR);
    sts_o.empty     = rem_q == 16'd0;
    sts_o.bad       = bad;
    sts_o.div_last  = div_cnt_q == 5'd16;
    sts_o.fits      = fit_sum <= 32'(limit);
    sts_o.byte_last = byte_last;
    sts_o.rem_zero  = rem_q == 16'd0;
  end

  assign status_o    = status_q;
  assign bit_value_o = bitv_q;

endmodule

FILE: rtl/core/blocked_bitmap_bit_engine.sv
// ----------------------------------------------------------------------------
// blocked_bitmap_bit_engine
// Tests one bit, or sets or clears a run of bits, in a blocked bitmap store.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low. Its one result
// word is shown for a single cycle with done_o high and cannot be stalled.
// After reset the store is cleared one byte a cycle, all 4096 bytes, with
// busy_o high. A command then passes through decoding, the start address
// division (one quotient bit a cycle) and block setup, then a read and a
// write state per byte touched for the read-modify-write of the store (a
// read and a bit-test state for a test), a setup and a check state for
// each further block of a run, and the result. An empty run, an unused
// command or a bad layout ends right after decoding.
module blocked_bitmap_bit_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [19:0] bit_address_i,
  input  logic [15:0] bit_count_i,
  output logic        done_o,
  output logic        status_o,
  output logic        bit_value_o
);
  import bbbe_pkg::*;

  cfg_t cfg_q;
  ctl_t ctl;
  sts_t sts;
  logic cfg_we;

  // Configuration registers.
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buffer_bytes  <= 13'd4096;
      cfg_q.block_bytes   <= 13'd512;
      cfg_q.header_bytes  <= 8'd4;
      cfg_q.trailer_bytes <= 8'd4;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_BUFFER:  cfg_q.buffer_bytes  <= pwdata[12:0];
        REG_BLOCK:   cfg_q.block_bytes   <= pwdata[12:0];
        REG_HEADER:  cfg_q.header_bytes  <= pwdata[7:0];
        REG_TRAILER: cfg_q.trailer_bytes <= pwdata[7:0];
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      REG_BUFFER:  prdata = {19'd0, cfg_q.buffer_bytes};
      REG_BLOCK:   prdata = {19'd0, cfg_q.block_bytes};
      REG_HEADER:  prdata = {24'd0, cfg_q.header_bytes};
      REG_TRAILER: prdata = {24'd0, cfg_q.trailer_bytes};
      default:     prdata = '0;
    endcase
  end

  bbbe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  bbbe_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .ctl_i         (ctl),
    .command_i     (command_i),
    .bit_address_i (bit_address_i),
    .bit_count_i   (bit_count_i),
    .sts_o         (sts),
    .status_o      (status_o),
    .bit_value_o   (bit_value_o)
  );

endmodule
